>>> design/dst_pkg.sv
// Shared types and constants for the dirty sector tracker.
package dst_pkg;

    localparam int PW        = 28;   // linear sector position width
    localparam int WORD_BITS = 64;   // sectors per store word
    localparam int MUL_W     = 14;   // shared multiplier operand width

    // configuration register indexes
    localparam logic [1:0] REG_SECTOR_SHIFT = 2'd0;
    localparam logic [1:0] REG_SCREEN_W     = 2'd1;
    localparam logic [1:0] REG_SCREEN_H     = 2'd2;

    localparam logic [3:0]  RST_SECTOR_SHIFT = 4'd3;
    localparam logic [12:0] RST_SCREEN_W     = 13'd1920;
    localparam logic [12:0] RST_SCREEN_H     = 13'd1080;

    typedef enum logic [1:0] {
        K_MARK  = 2'd0,
        K_QUERY = 2'd1,
        K_CLEAR = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_LIM,
        S_START,
        S_SPAN,
        S_SEG,
        S_ROW,
        S_RD,
        S_WR,
        S_QCHK,
        S_QWR,
        S_DONE
    } t_state;

endpackage

>>> design/dirty_sector_tracker.sv
// Dirty sector tracker top level: sequencer around a shared multiplier and a word-wide store.
// Reset (i_rst_n low, synchronous) restores config and control registers, then a fill pass
// sets all ceil(MAX_SECTORS/64) store words (512 by default) to ones; o_ready low throughout.
// One item at a time: o_ready is low until the result is registered, which waits on i_ready.
// Zero-area marks and unused kinds skip the store; query/clear range-check, then read (clear:
// and write) one word; marks read and write each word a run touches; touching runs merge.
module dirty_sector_tracker #(
    parameter int MAX_SECTORS = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_rect_x,
    input  logic [11:0] i_rect_y,
    input  logic [12:0] i_rect_w,
    input  logic [12:0] i_rect_h,
    input  logic [14:0] i_sector_index,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic        o_needs_update,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import dst_pkg::*;

    localparam int STORE_WORDS = (MAX_SECTORS + 63) / 64;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);
    localparam logic [PW-1:0] MAX_POS   = PW'(MAX_SECTORS);

    // config registers
    logic [3:0]  r_shift;
    logic [12:0] r_width;
    logic [12:0] r_height;

    // sequencer
    t_state        r_state, n_state;
    logic [AW-1:0] r_fill, n_fill;
    t_kind         r_kind, n_kind;
    logic [11:0]   r_x_s, n_x_s;          // x >> shift
    logic [11:0]   r_y_s, n_y_s;          // y >> shift
    logic [12:0]   r_len, n_len;          // run length in sectors
    logic [12:0]   r_rows, n_rows;        // run count
    logic [14:0]   r_idx, n_idx;
    logic [PW-1:0] r_limit, n_limit;      // live sector count
    logic [PW-1:0] r_seg_start, n_seg_start;
    logic [PW-1:0] r_seglen, n_seglen;
    logic [12:0]   r_rows_left, n_rows_left;
    logic [PW-1:0] r_lo, n_lo;            // walking position within a run
    logic [PW-1:0] r_hi, n_hi;            // clipped run end
    logic          r_status, n_status;
    logic          r_need, n_need;
    // output register
    logic          r_ovalid, n_ovalid;
    logic          r_ostatus, n_ostatus;
    logic          r_oneed, n_oneed;

    // datapath wiring
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [PW-1:0]        mul_p;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
    logic [WORD_BITS-1:0] lo_mask;

    logic [12:0]   step;
    logic [MUL_W-1:0] cols, rows_c;
    logic [AW-1:0] word_lo, word_idx;
    logic [PW-1:0] idx_pos, seg_end;

    assign step     = r_width >> r_shift;
    assign cols     = {1'b0, r_width >> r_shift} + MUL_W'(1);
    assign rows_c   = {1'b0, r_height >> r_shift} + MUL_W'(1);
    assign word_lo  = r_lo[6 +: AW];
    assign idx_pos  = PW'(r_idx);
    assign word_idx = idx_pos[6 +: AW];
    assign seg_end  = r_seg_start + r_seglen;

    dst_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    dst_mask u_mask (
        .i_lo   (r_lo),
        .i_hi   (r_hi),
        .o_mask (lo_mask)
    );

    dst_ram #(
        .DEPTH (STORE_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Config writes land whenever offered; indexes beyond the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= RST_SECTOR_SHIFT;
            r_width  <= RST_SCREEN_W;
            r_height <= RST_SCREEN_H;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SECTOR_SHIFT: r_shift  <= i_cfg_data[3:0];
                REG_SCREEN_W:     r_width  <= i_cfg_data;
                REG_SCREEN_H:     r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_x_s       <= n_x_s;
        r_y_s       <= n_y_s;
        r_len       <= n_len;
        r_rows      <= n_rows;
        r_idx       <= n_idx;
        r_limit     <= n_limit;
        r_seg_start <= n_seg_start;
        r_seglen    <= n_seglen;
        r_rows_left <= n_rows_left;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_status    <= n_status;
        r_need      <= n_need;
        r_ostatus   <= n_ostatus;
        r_oneed     <= n_oneed;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_kind      = r_kind;
        n_x_s       = r_x_s;
        n_y_s       = r_y_s;
        n_len       = r_len;
        n_rows      = r_rows;
        n_idx       = r_idx;
        n_limit     = r_limit;
        n_seg_start = r_seg_start;
        n_seglen    = r_seglen;
        n_rows_left = r_rows_left;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_status    = r_status;
        n_need      = r_need;
        n_ostatus   = r_ostatus;
        n_oneed     = r_oneed;
        n_ovalid    = r_ovalid && !i_ready;

        mul_a     = '0;
        mul_b     = '0;
        ram_we    = 1'b0;
        ram_waddr = word_lo;
        ram_wdata = ram_rdata | lo_mask;
        ram_raddr = word_lo;

        unique case (r_state)
            // post-reset sweep: every sector dirty
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_fill;
                ram_wdata = {WORD_BITS{1'b1}};
                n_fill    = r_fill + AW'(1);
                if (r_fill == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_kind   = t_kind'(i_kind);
                    n_x_s    = i_rect_x >> r_shift;
                    n_y_s    = i_rect_y >> r_shift;
                    n_len    = i_rect_w >> r_shift;
                    n_rows   = i_rect_h >> r_shift;
                    n_idx    = i_sector_index;
                    n_status = 1'b0;
                    n_need   = 1'b0;
                    unique case (t_kind'(i_kind)) inside
                        K_MARK: begin
                            if (i_rect_w == '0 || i_rect_h == '0) begin
                                n_status = 1'b1;
                                n_state  = S_DONE;
                            end else if ((i_rect_w >> r_shift) == '0 ||
                                         (i_rect_h >> r_shift) == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_LIM;
                            end
                        end
                        K_QUERY, K_CLEAR: n_state = S_LIM;
                        default:          n_state = S_DONE;
                    endcase
                end
            end
            // live count = cols * rows
            S_LIM: begin
                mul_a   = cols;
                mul_b   = rows_c;
                n_state = S_START;
            end
            S_START: begin
                n_limit = (mul_p > MAX_POS) ? MAX_POS : mul_p;
                mul_a   = {2'b0, r_y_s};
                mul_b   = {1'b0, step};
                n_state = (r_kind == K_MARK) ? S_SPAN : S_QCHK;
            end
            S_SPAN: begin
                n_seg_start = mul_p + PW'(r_x_s);
                mul_a       = {1'b0, r_rows - 13'd1};
                mul_b       = {1'b0, step};
                n_state     = S_SEG;
            end
            // touching or overlapping runs collapse into one range
            S_SEG: begin
                if (step <= r_len) begin
                    n_seglen    = mul_p + PW'(r_len);
                    n_rows_left = 13'd1;
                end else begin
                    n_seglen    = PW'(r_len);
                    n_rows_left = r_rows;
                end
                n_state = S_ROW;
            end
            S_ROW: begin
                if (r_rows_left == '0 || r_seg_start >= r_limit) begin
                    n_state = S_DONE;
                end else begin
                    n_lo    = r_seg_start;
                    n_hi    = (seg_end > r_limit) ? r_limit : seg_end;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_lo >= r_hi) begin
                    n_seg_start = r_seg_start + PW'(step);
                    n_rows_left = r_rows_left - 13'd1;
                    n_state     = S_ROW;
                end else begin
                    ram_raddr = word_lo;
                    n_state   = S_WR;
                end
            end
            S_WR: begin
                ram_we    = 1'b1;
                ram_waddr = word_lo;
                ram_wdata = ram_rdata | lo_mask;
                n_lo      = {r_lo[PW-1:6] + (PW-6)'(1), 6'd0};
                n_state   = S_RD;
            end
            S_QCHK: begin
                ram_raddr = word_idx;
                n_state   = (idx_pos < r_limit) ? S_QWR : S_DONE;
            end
            S_QWR: begin
                if (r_kind == K_QUERY) begin
                    n_need = ram_rdata[r_idx[5:0]];
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = word_idx;
                    ram_wdata = ram_rdata & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << r_idx[5:0]);
                end
                n_state = S_DONE;
            end
            // hand over once the output register is free
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oneed   = r_need;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_needs_update = r_oneed;
endmodule

>>> design/dst_mul.sv
// Shared multiplier with a registered product.
module dst_mul (
    input  logic                                      i_clk,
    input  logic [dst_pkg::MUL_W-1:0]                 i_a,
    input  logic [dst_pkg::MUL_W-1:0]                 i_b,
    output logic [dst_pkg::PW-1:0]                    o_p
);
    import dst_pkg::*;

    logic [PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

>>> design/dst_mask.sv
// Bit mask of the sectors in [lo, hi) that fall in lo's store word.
module dst_mask (
    input  logic [dst_pkg::PW-1:0]        i_lo,
    input  logic [dst_pkg::PW-1:0]        i_hi,
    output logic [dst_pkg::WORD_BITS-1:0] o_mask
);
    import dst_pkg::*;

    logic                 same_word;
    logic [WORD_BITS-1:0] lo_part;
    logic [WORD_BITS-1:0] hi_part;

    always_comb begin
        same_word = (i_hi[PW-1:6] == i_lo[PW-1:6]);
        lo_part   = {WORD_BITS{1'b1}} << i_lo[5:0];
        hi_part   = same_word ? ~({WORD_BITS{1'b1}} << i_hi[5:0]) : {WORD_BITS{1'b1}};
        o_mask    = lo_part & hi_part;
    end
endmodule

>>> design/dst_ram.sv
// Dirty bit store: one write port, one registered read port.
module dst_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [dst_pkg::WORD_BITS-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [dst_pkg::WORD_BITS-1:0] o_rdata
);
    import dst_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/dst_checker.sv
// Port-level checker for the dirty sector tracker, bound to the top level.
module dst_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_status,
    input logic o_needs_update
);

    // fill pass holds off items straight after reset
    a_fill_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_ready)
        else $error("item channel ready during fill pass");

    // one item at a time
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held after input transfer");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_needs_update)))
        else $error("stalled result changed");

    // an invalid rectangle never reports a dirty sector
    a_status_need_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_status && o_needs_update))
        else $error("status and needs_update both set");

endmodule

bind dirty_sector_tracker dst_checker u_dst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_needs_update (o_needs_update)
);
